### rtl/suffix_array_lcp_builder_assert.svh
// Assertion macros shared by the checker of the suffix array builder.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH
// The consequent must hold in the same cycle as the antecedent.
`define SAPL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define SAPL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`endif

### rtl/sapl_pkg.sv
// Package for the suffix array and LCP builder: request and response types,
// operation and status codes, sequencer states. Depends on nothing.
package sapl_pkg;
	localparam int PORT_W       = 11;
	localparam int CHAR_W       = 8;
	localparam int CHAR_BUCKETS = 256;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_BUILD  = 2'd1,
		OP_RANK   = 2'd2,
		OP_LCP    = 2'd3
	} op_t;

	typedef enum logic {
		ST_OK     = 1'b0,
		ST_REJECT = 1'b1
	} status_t;

	typedef struct packed {
		op_t                 operation;
		logic [CHAR_W-1:0]   char_value;
		logic [PORT_W-1:0]   rank_a;
		logic [PORT_W-1:0]   rank_b;
	} req_t;

	typedef struct packed {
		logic [PORT_W-1:0]   suffix_start;
		logic [PORT_W-1:0]   lcp_value;
		logic [PORT_W-1:0]   text_length;
		status_t             status;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CLR, S_HIST1, S_PFX, S_SCAT1, S_RANK1, S_SC1, S_SC2, S_HIST2,
		S_SCAT2, S_COPY, S_RANK2, S_LCP, S_SPARSE, S_FIN, S_QRY, S_LOG, S_RMQ, S_OUT
	} state_t;
endpackage

### rtl/suffix_array_lcp_builder.sv
// Appends and rejected requests answer in the cycle after they are accepted; one request
// is taken per cycle while the builder is idle and the response is not stalled. Rank
// and LCP queries and builds answer from S_OUT; a build sorts by counting, doubles the
// compared prefix length each round, then fills the LCP array and its sparse table.
// Every step is one access per memory; reset clears the length, the built flag
// and the sequencer, and the stores are not cleared.
module suffix_array_lcp_builder #(
	parameter int MAX_LEN    = 1024,
	parameter int LOG_LEVELS = 11
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sapl_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sapl_pkg::rsp_t  rsp
);
	import sapl_pkg::*;

	localparam int VW  = $clog2(MAX_LEN + 1);
	localparam int CW  = $clog2(MAX_LEN + CHAR_BUCKETS + 1);
	localparam int LAW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
	localparam int LW  = $clog2(LOG_LEVELS + 1);
	localparam int SW  = CW + 2;
	localparam int XW  = (VW > PORT_W) ? VW : PORT_W;

	state_t           state_q, state_d;
	logic [2:0]       ph_q;
	logic [CW-1:0]    i_q;
	logic [VW-1:0]    j_q, h_q, a_q, q_q, r_q, pa_q, pb_q, skb_q, acc_q, len_q;
	logic [VW:0]      k_q;
	logic [CHAR_W-1:0] ch_q, prevch_q;
	logic [LW-1:0]    lv_q;
	logic             pass_q, built_q;
	op_t              op_q;
	logic [VW-1:0]    ra_q, rb_q, res_start_q, res_lcp_q;
	status_t          res_st_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic              txt_we, sa_we, rk_we, pr_we, cnt_we, sc_we, lt_we;
	logic [VW-1:0]     txt_wa, txt_ra, sa_wa, sa_ra, rk_wa, rk_ra, pr_wa, pr_ra;
	logic [VW-1:0]     sc_wa, sc_ra;
	logic [CW-1:0]     cnt_wa, cnt_ra;
	logic [LAW+VW-1:0] lt_wa, lt_ra;
	logic [CHAR_W-1:0] txt_wd, txt_rd;
	logic [VW-1:0]     sa_wd, sa_rd, rk_wd, rk_rd, pr_wd, pr_rd, cnt_wd, cnt_rd;
	logic [VW-1:0]     sc_wd, sc_rd, lt_wd, lt_rd;

	logic             req_acc, out_free, app_wr, qbad, rsp_load;
	logic [SW-1:0]    n_s, i_s, h_s, q_s, k_s, k2_s, pw_s, half_s;
	logic             end_c, lvl_end, row_end, kin, log_done;
	logic             rank1_inc, rank2_inc;
	logic [VW-1:0]    j_inc, ska_c, min_c;
	logic [LAW-1:0]   lva, lvm1;
	logic [VW-1:0]    iv;

	assign req_acc  = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A response is loaded for appends and rejected queries at once, else from S_OUT.
	assign rsp_load = ((state_q == S_IDLE) && req_acc &&
		((req.operation == OP_APPEND) || ((req.operation != OP_BUILD) && qbad))) ||
		((state_q == S_OUT) && out_free);

	assign n_s    = SW'(len_q);
	assign i_s    = SW'(i_q);
	assign h_s    = SW'(h_q);
	assign q_s    = SW'(q_q);
	assign k_s    = SW'(k_q);
	assign k2_s   = k_s << 1;
	assign pw_s   = SW'(1) << lv_q;
	assign half_s = pw_s >> 1;
	assign iv     = i_q[VW-1:0];
	assign lva    = lv_q[LAW-1:0];
	assign lvm1   = LAW'(lv_q - 1'b1);
	assign j_inc  = j_q + 1'b1;

	assign app_wr = (req.char_value != '0) && (built_q || (len_q != VW'(MAX_LEN)));
	assign qbad   = !built_q || (req.rank_a == '0) || (XW'(req.rank_a) > XW'(len_q)) ||
		((req.operation == OP_LCP) &&
		 ((req.rank_b == '0) || (XW'(req.rank_b) > XW'(len_q))));

	assign rank1_inc = (j_q == '0) || (txt_rd > prevch_q);
	assign ska_c     = ((SW'(a_q) + k_s) < n_s) ? pr_rd : '0;
	assign rank2_inc = (j_q == '0) || (pa_q > pb_q) || ((pa_q == pb_q) && (ska_c > skb_q));
	assign min_c     = (pa_q < lt_rd) ? pa_q : lt_rd;
	assign kin       = ((i_s + h_s) < n_s) && ((q_s + h_s) < n_s);
	assign lvl_end   = (int'(lv_q) >= LOG_LEVELS) || (pw_s > n_s);
	assign row_end   = (i_s + pw_s) > (n_s + 1'b1);
	assign log_done  = (int'(lv_q) >= LOG_LEVELS - 1) || ((h_q >> (lv_q + 1'b1)) == '0);

	// Loop exit test, evaluated at the first step of each iteration.
	always_comb begin
		end_c = 1'b0;
		case (state_q)
			S_CLR:                          end_c = (i_s == n_s + SW'(CHAR_BUCKETS - 1));
			S_HIST1, S_COPY, S_LCP, S_SC1:  end_c = (i_s >= n_s);
			S_PFX:    end_c = (i_s > (pass_q ? n_s : SW'(CHAR_BUCKETS - 1)));
			S_SCAT1, S_SCAT2:               end_c = (i_q == '0);
			S_RANK1, S_SC2, S_HIST2, S_RANK2: end_c = (i_s > n_s);
			default:                        end_c = 1'b0;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc && req.operation == OP_BUILD) begin
					state_d = S_CLR;
				end else if (req_acc && (req.operation == OP_RANK || req.operation == OP_LCP)
						&& !qbad) begin
					state_d = S_QRY;
				end
			end
			S_CLR:    if (end_c) state_d = pass_q ? S_HIST2 : S_HIST1;
			S_HIST1:  if (ph_q == 3'd0 && end_c) state_d = S_PFX;
			S_PFX:    if (ph_q == 3'd0 && end_c) state_d = pass_q ? S_SCAT2 : S_SCAT1;
			S_SCAT1:  if (ph_q == 3'd0 && end_c) state_d = S_RANK1;
			S_RANK1:  if (ph_q == 3'd0 && end_c) state_d = (n_s > SW'(1)) ? S_SC1 : S_LCP;
			S_SC1:    if (end_c) state_d = S_SC2;
			S_SC2:    if (ph_q == 3'd0 && end_c) state_d = S_CLR;
			S_HIST2:  if (ph_q == 3'd0 && end_c) state_d = S_PFX;
			S_SCAT2:  if (ph_q == 3'd0 && end_c) state_d = S_COPY;
			S_COPY:   if (ph_q == 3'd0 && end_c) state_d = S_RANK2;
			S_RANK2:  if (ph_q == 3'd0 && end_c) state_d = (k2_s < n_s) ? S_SC1 : S_LCP;
			S_LCP:    if (ph_q == 3'd0 && end_c) state_d = S_SPARSE;
			S_SPARSE: if (ph_q == 3'd0 && lvl_end) state_d = S_FIN;
			S_FIN:    state_d = S_OUT;
			S_QRY: begin
				if (ph_q == 3'd1) begin
					if (op_q == OP_RANK) begin
						if (ra_q == VW'(1)) state_d = S_OUT;
					end else if (ra_q == rb_q) begin
						state_d = S_OUT;
					end else begin
						state_d = S_LOG;
					end
				end else if (ph_q == 3'd2) begin
					state_d = S_OUT;
				end
			end
			S_LOG:    if (log_done) state_d = S_RMQ;
			S_RMQ:    if (ph_q == 3'd2) state_d = S_OUT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory ports.
	always_comb begin
		txt_we = 1'b0; txt_wa = '0; txt_wd = '0; txt_ra = '0;
		sa_we  = 1'b0; sa_wa  = '0; sa_wd  = '0; sa_ra  = '0;
		rk_we  = 1'b0; rk_wa  = '0; rk_wd  = '0; rk_ra  = '0;
		pr_we  = 1'b0; pr_wa  = '0; pr_wd  = '0; pr_ra  = '0;
		cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
		sc_we  = 1'b0; sc_wa  = '0; sc_wd  = '0; sc_ra  = '0;
		lt_we  = 1'b0; lt_wa  = '0; lt_wd  = '0; lt_ra  = '0;
		case (state_q)
			S_IDLE: begin
				txt_we = req_acc && (req.operation == OP_APPEND) && app_wr;
				txt_wa = built_q ? '0 : len_q;
				txt_wd = req.char_value;
			end
			S_CLR: begin
				cnt_we = 1'b1;
				cnt_wa = i_q;
			end
			S_HIST1: begin
				txt_ra = iv;
				cnt_ra = CW'(txt_rd);
				cnt_we = (ph_q == 3'd2);
				cnt_wa = CW'(ch_q);
				cnt_wd = cnt_rd + 1'b1;
			end
			S_PFX: begin
				cnt_ra = i_q;
				cnt_we = (ph_q == 3'd1);
				cnt_wa = i_q;
				cnt_wd = cnt_rd + acc_q;
			end
			S_SCAT1: begin
				txt_ra = VW'(i_q - 1'b1);
				cnt_ra = CW'(txt_rd);
				sa_we  = (ph_q == 3'd2);
				sa_wa  = cnt_rd;
				sa_wd  = VW'(i_q - 1'b1);
				cnt_we = (ph_q == 3'd2);
				cnt_wa = CW'(ch_q);
				cnt_wd = cnt_rd - 1'b1;
			end
			S_RANK1: begin
				sa_ra  = iv;
				txt_ra = sa_rd;
				rk_we  = (ph_q == 3'd2);
				rk_wa  = a_q;
				rk_wd  = rank1_inc ? j_inc : j_q;
			end
			S_SC1: begin
				sc_we = !end_c;
				sc_wa = j_inc;
				sc_wd = iv;
			end
			S_SC2: begin
				sa_ra = iv;
				sc_we = (ph_q == 3'd1) && ({1'b0, sa_rd} >= k_q);
				sc_wa = j_inc;
				sc_wd = VW'({1'b0, sa_rd} - k_q);
			end
			S_HIST2: begin
				sc_ra  = iv;
				rk_ra  = sc_rd;
				cnt_ra = CW'(rk_rd);
				cnt_we = (ph_q == 3'd3);
				cnt_wa = CW'(r_q);
				cnt_wd = cnt_rd + 1'b1;
			end
			S_SCAT2: begin
				sc_ra  = iv;
				rk_ra  = sc_rd;
				cnt_ra = CW'(rk_rd);
				sa_we  = (ph_q == 3'd3);
				sa_wa  = cnt_rd;
				sa_wd  = a_q;
				cnt_we = (ph_q == 3'd3);
				cnt_wa = CW'(r_q);
				cnt_wd = cnt_rd - 1'b1;
			end
			S_COPY: begin
				rk_ra = iv;
				pr_we = (ph_q == 3'd1);
				pr_wa = iv;
				pr_wd = rk_rd;
			end
			S_RANK2: begin
				sa_ra = iv;
				pr_ra = (ph_q == 3'd1) ? sa_rd : VW'(SW'(a_q) + k_s);
				rk_we = (ph_q == 3'd3);
				rk_wa = a_q;
				rk_wd = rank2_inc ? j_inc : j_q;
			end
			S_LCP: begin
				rk_ra  = iv;
				sa_ra  = rk_rd - 1'b1;
				txt_ra = (ph_q == 3'd3) ? VW'(i_s + h_s) : VW'(q_s + h_s);
				if (ph_q == 3'd1 && rk_rd <= VW'(1)) begin
					lt_we = 1'b1;
					lt_wa = {LAW'(0), VW'(1)};
					lt_wd = '0;
				end else if (ph_q == 3'd6) begin
					lt_we = 1'b1;
					lt_wa = {LAW'(0), r_q};
					lt_wd = h_q;
				end
			end
			S_SPARSE: begin
				lt_ra = (ph_q == 3'd0) ? {lvm1, iv} : {lvm1, VW'(i_s + half_s)};
				lt_we = (ph_q == 3'd2);
				lt_wa = {lva, iv};
				lt_wd = min_c;
			end
			S_QRY: begin
				sa_ra = ra_q;
				lt_ra = {LAW'(0), ra_q};
			end
			S_RMQ: begin
				lt_ra = (ph_q == 3'd0) ? {lva, a_q} : {lva, VW'(q_s - pw_s + 1'b1)};
			end
			default: ;
		endcase
	end

	sapl_ram #(.W(CHAR_W), .AW(VW)) u_txt (.clk(clk), .we(txt_we), .wa(txt_wa), .wd(txt_wd),
		.ra(txt_ra), .rd(txt_rd));
	sapl_ram #(.W(VW), .AW(VW)) u_sa (.clk(clk), .we(sa_we), .wa(sa_wa), .wd(sa_wd),
		.ra(sa_ra), .rd(sa_rd));
	sapl_ram #(.W(VW), .AW(VW)) u_rk (.clk(clk), .we(rk_we), .wa(rk_wa), .wd(rk_wd),
		.ra(rk_ra), .rd(rk_rd));
	sapl_ram #(.W(VW), .AW(VW)) u_pr (.clk(clk), .we(pr_we), .wa(pr_wa), .wd(pr_wd),
		.ra(pr_ra), .rd(pr_rd));
	sapl_ram #(.W(VW), .AW(CW)) u_cnt (.clk(clk), .we(cnt_we), .wa(cnt_wa), .wd(cnt_wd),
		.ra(cnt_ra), .rd(cnt_rd));
	sapl_ram #(.W(VW), .AW(VW)) u_sc (.clk(clk), .we(sc_we), .wa(sc_wa), .wd(sc_wd),
		.ra(sc_ra), .rd(sc_rd));
	sapl_ram #(.W(VW), .AW(LAW + VW)) u_lt (.clk(clk), .we(lt_we), .wa(lt_wa), .wd(lt_wd),
		.ra(lt_ra), .rd(lt_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ph_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0; h_q <= '0;
			a_q <= '0; q_q <= '0; r_q <= '0; pa_q <= '0; pb_q <= '0; skb_q <= '0;
			acc_q <= '0; len_q <= '0; ch_q <= '0; prevch_q <= '0; lv_q <= '0;
			pass_q <= 1'b0; built_q <= 1'b0; op_q <= OP_APPEND; ra_q <= '0; rb_q <= '0;
			res_start_q <= '0; res_lcp_q <= '0; res_st_q <= ST_OK;
			rsp_q <= '0; rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						case (req.operation)
							OP_APPEND: begin
								rsp_q.suffix_start <= '0;
								rsp_q.lcp_value <= '0;
								if (!app_wr) begin
									rsp_q.status <= ST_REJECT;
									rsp_q.text_length <= PORT_W'(len_q);
								end else if (built_q) begin
									built_q <= 1'b0;
									len_q <= VW'(1);
									rsp_q.status <= ST_OK;
									rsp_q.text_length <= PORT_W'(1);
								end else begin
									len_q <= len_q + 1'b1;
									rsp_q.status <= ST_OK;
									rsp_q.text_length <= PORT_W'(len_q + 1'b1);
								end
							end
							OP_BUILD: begin
								i_q <= '0;
								pass_q <= 1'b0;
							end
							default: begin
								if (qbad) begin
									rsp_q.suffix_start <= '0;
									rsp_q.lcp_value <= '0;
									rsp_q.status <= ST_REJECT;
									rsp_q.text_length <= PORT_W'(len_q);
								end
								op_q <= req.operation;
								ra_q <= VW'(req.rank_a);
								rb_q <= VW'(req.rank_b);
							end
						endcase
					end
				end
				S_CLR: i_q <= end_c ? (pass_q ? CW'(1) : '0) : i_q + 1'b1;
				S_HIST1: begin
					if (ph_q == 3'd0) begin
						if (end_c) begin
							i_q <= '0;
							acc_q <= '0;
						end else begin
							ph_q <= 3'd1;
						end
					end else if (ph_q == 3'd1) begin
						ch_q <= txt_rd;
						ph_q <= 3'd2;
					end else begin
						i_q <= i_q + 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_PFX: begin
					if (ph_q == 3'd0) begin
						if (end_c) i_q <= CW'(len_q);
						else ph_q <= 3'd1;
					end else begin
						acc_q <= cnt_rd + acc_q;
						i_q <= i_q + 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_SCAT1: begin
					if (ph_q == 3'd0) begin
						if (end_c) begin
							i_q <= CW'(1);
							j_q <= '0;
							prevch_q <= '0;
						end else begin
							ph_q <= 3'd1;
						end
					end else if (ph_q == 3'd1) begin
						ch_q <= txt_rd;
						ph_q <= 3'd2;
					end else begin
						i_q <= i_q - 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_RANK1: begin
					if (ph_q == 3'd0) begin
						if (end_c) begin
							k_q <= (VW + 1)'(1);
							j_q <= '0;
							h_q <= '0;
							i_q <= (n_s > SW'(1)) ? CW'(n_s - 1'b1) : '0;
						end else begin
							ph_q <= 3'd1;
						end
					end else if (ph_q == 3'd1) begin
						a_q <= sa_rd;
						ph_q <= 3'd2;
					end else begin
						if (rank1_inc) j_q <= j_inc;
						prevch_q <= txt_rd;
						i_q <= i_q + 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_SC1: begin
					if (end_c) begin
						i_q <= CW'(1);
					end else begin
						j_q <= j_inc;
						i_q <= i_q + 1'b1;
					end
				end
				S_SC2: begin
					if (ph_q == 3'd0) begin
						if (end_c) begin
							i_q <= '0;
							pass_q <= 1'b1;
						end else begin
							ph_q <= 3'd1;
						end
					end else begin
						if ({1'b0, sa_rd} >= k_q) j_q <= j_inc;
						i_q <= i_q + 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_HIST2: begin
					if (ph_q == 3'd0) begin
						if (end_c) begin
							i_q <= '0;
							acc_q <= '0;
						end else begin
							ph_q <= 3'd1;
						end
					end else if (ph_q == 3'd1) begin
						ph_q <= 3'd2;
					end else if (ph_q == 3'd2) begin
						r_q <= rk_rd;
						ph_q <= 3'd3;
					end else begin
						i_q <= i_q + 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_SCAT2: begin
					if (ph_q == 3'd0) begin
						if (end_c) i_q <= '0;
						else ph_q <= 3'd1;
					end else if (ph_q == 3'd1) begin
						a_q <= sc_rd;
						ph_q <= 3'd2;
					end else if (ph_q == 3'd2) begin
						r_q <= rk_rd;
						ph_q <= 3'd3;
					end else begin
						i_q <= i_q - 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_COPY: begin
					if (ph_q == 3'd0) begin
						if (end_c) begin
							i_q <= CW'(1);
							j_q <= '0;
						end else begin
							ph_q <= 3'd1;
						end
					end else begin
						i_q <= i_q + 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_RANK2: begin
					if (ph_q == 3'd0) begin
						if (end_c) begin
							k_q <= (VW + 1)'(k2_s);
							j_q <= '0;
							h_q <= '0;
							i_q <= (k2_s < n_s) ? CW'(n_s - k2_s) : '0;
						end else begin
							ph_q <= 3'd1;
						end
					end else if (ph_q == 3'd1) begin
						a_q <= sa_rd;
						ph_q <= 3'd2;
					end else if (ph_q == 3'd2) begin
						pa_q <= pr_rd;
						ph_q <= 3'd3;
					end else begin
						if (rank2_inc) j_q <= j_inc;
						pb_q <= pa_q;
						skb_q <= ska_c;
						i_q <= i_q + 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_LCP: begin
					unique case (ph_q)
						3'd0: begin
							if (end_c) begin
								lv_q <= LW'(1);
								i_q <= CW'(1);
							end else begin
								ph_q <= 3'd1;
							end
						end
						3'd1: begin
							r_q <= rk_rd;
							if (rk_rd <= VW'(1)) begin
								h_q <= '0;
								i_q <= i_q + 1'b1;
								ph_q <= 3'd0;
							end else begin
								ph_q <= 3'd2;
							end
						end
						3'd2: begin
							q_q <= sa_rd;
							ph_q <= 3'd3;
						end
						3'd3: ph_q <= kin ? 3'd4 : 3'd6;
						3'd4: begin
							ch_q <= txt_rd;
							ph_q <= 3'd5;
						end
						3'd5: begin
							if (txt_rd == ch_q) begin
								h_q <= h_q + 1'b1;
								ph_q <= 3'd3;
							end else begin
								ph_q <= 3'd6;
							end
						end
						default: begin
							h_q <= (h_q != '0) ? h_q - 1'b1 : '0;
							i_q <= i_q + 1'b1;
							ph_q <= 3'd0;
						end
					endcase
				end
				S_SPARSE: begin
					if (ph_q == 3'd0) begin
						if (!lvl_end) begin
							if (row_end) begin
								lv_q <= lv_q + 1'b1;
								i_q <= CW'(1);
							end else begin
								ph_q <= 3'd1;
							end
						end
					end else if (ph_q == 3'd1) begin
						pa_q <= lt_rd;
						ph_q <= 3'd2;
					end else begin
						i_q <= i_q + 1'b1;
						ph_q <= 3'd0;
					end
				end
				S_FIN: begin
					built_q <= 1'b1;
					res_start_q <= '0;
					res_lcp_q <= '0;
					res_st_q <= ST_OK;
				end
				S_QRY: begin
					if (ph_q == 3'd0) begin
						ph_q <= 3'd1;
					end else if (ph_q == 3'd1) begin
						res_start_q <= sa_rd + 1'b1;
						res_st_q <= ST_OK;
						res_lcp_q <= '0;
						if (op_q == OP_RANK) begin
							if (ra_q != VW'(1)) ph_q <= 3'd2;
						end else if (ra_q == rb_q) begin
							res_lcp_q <= len_q;
						end else begin
							// Span runs from the lower rank plus one up to the higher rank.
							a_q <= ((ra_q < rb_q) ? ra_q : rb_q) + 1'b1;
							q_q <= (ra_q < rb_q) ? rb_q : ra_q;
							h_q <= (ra_q < rb_q) ? rb_q - ra_q : ra_q - rb_q;
							lv_q <= '0;
						end
					end else begin
						res_lcp_q <= lt_rd;
					end
				end
				S_LOG: if (!log_done) lv_q <= lv_q + 1'b1;
				S_RMQ: begin
					if (ph_q == 3'd0) begin
						ph_q <= 3'd1;
					end else if (ph_q == 3'd1) begin
						pa_q <= lt_rd;
						ph_q <= 3'd2;
					end else begin
						res_lcp_q <= min_c;
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_q.suffix_start <= PORT_W'(res_start_q);
						rsp_q.lcp_value <= PORT_W'(res_lcp_q);
						rsp_q.text_length <= PORT_W'(len_q);
						rsp_q.status <= res_st_q;
					end
				end
				default: ;
			endcase
			if (state_d != state_q) ph_q <= '0;
		end
	end
endmodule

### rtl/sapl_ram.sv
// Simple dual-port memory: one write port, one read port with registered data.
// Used for every store of the suffix array builder. No dependencies.
module sapl_ram #(
	parameter int W  = 8,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [W-1:0]  wd,
	input  logic [AW-1:0] ra,
	output logic [W-1:0]  rd
);
	logic [W-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end
endmodule

### rtl/sapl_checker.sv
// Port-level checker for the suffix array builder, bound to the top level.
// Depends on sapl_pkg and the assertion macro header.
`include "suffix_array_lcp_builder_assert.svh"
module sapl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input sapl_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input sapl_pkg::rsp_t rsp
);
	import sapl_pkg::*;

	// A stalled response must stay put.
	`SAPL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	// Rejected responses carry no position and no prefix length.
	`SAPL_ASSERT_SAME(a_rej_zero, rsp_valid && rsp.status == ST_REJECT, rsp.suffix_start == '0 && rsp.lcp_value == '0)
	// A zero character is answered at once with a rejection.
	`SAPL_ASSERT_NEXT(a_zero_char, req_valid && !req_stall && req.operation == OP_APPEND && req.char_value == '0, rsp_valid && rsp.status == ST_REJECT)
	// A query naming rank zero is answered at once with a rejection.
	`SAPL_ASSERT_NEXT(a_rank_zero, req_valid && !req_stall && (req.operation == OP_RANK || req.operation == OP_LCP) && req.rank_a == '0, rsp_valid && rsp.status == ST_REJECT)
endmodule

bind suffix_array_lcp_builder sapl_checker u_sapl_checker (.*);
